FILE: sv/tcat_pkg.sv
`timescale 1ns / 1ps

package tcat_pkg;

  // Default coordinate width of the vertex fields
  localparam int COORD_BITS_DEF = 16;

  // Width of the alpha register
  localparam int ALPHA_BITS = 24;

  // Slice width of the partial-product multiplier and its depth in cycles
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 4;

endpackage

FILE: sv/tcat_delay.sv
`timescale 1ns / 1ps

module tcat_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  // advance the whole line together with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: sv/tcat_mul.sv
`timescale 1ns / 1ps

module tcat_mul #(
  parameter int WA = 16,
  parameter int WB = 16,
  parameter int WP = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WP-1:0] p
);

  import tcat_pkg::*;

  localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int FW = (NA + NB) * MUL_CHUNK;

  logic [WA-1:0]             a_mag;
  logic [WB-1:0]             b_mag;
  logic [NA*MUL_CHUNK-1:0]   a_abs;
  logic [NB*MUL_CHUNK-1:0]   b_abs;
  logic                      neg1;
  logic                      neg2;
  logic                      neg3;
  logic [2*MUL_CHUNK-1:0]    pp [NA*NB];
  logic [FW-1:0]             sum_comb;
  logic [FW-1:0]             mag;

  assign a_mag = a[WA-1] ? WA'(~a + 1'b1) : WA'(a);
  assign b_mag = b[WB-1] ? WB'(~b + 1'b1) : WB'(b);

  // sum the shifted slice products
  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_comb = sum_comb + (FW'(pp[i*NB+j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_abs <= (NA*MUL_CHUNK)'(a_mag);
      b_abs <= (NB*MUL_CHUNK)'(b_mag);
      neg1  <= a[WA-1] ^ b[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i*NB+j] <= a_abs[i*MUL_CHUNK +: MUL_CHUNK] * b_abs[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
      neg2 <= neg1;
      mag  <= sum_comb;
      neg3 <= neg2;
      p    <= WP'(neg3 ? (~mag + 1'b1) : mag);
    end
  end

endmodule

FILE: sv/tetra_circumradius_alpha_test_unit.sv
`timescale 1ns / 1ps

// Alpha-shape circumradius test for a stream of tetrahedra.
//
// Input channel (in_valid / in_ready): one transfer carries the twelve signed
// vertex coordinates of one tetrahedron. Output channel (out_valid /
// out_ready): one transfer per input carries keep and degenerate, in input
// order. Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// alpha register; cfg_ready is always high. Write alpha only while the block
// holds no item in flight.
//
// Throughput is one tetrahedron per cycle while results are taken. After the
// vertex subtraction, four rounds of sliced multipliers follow, each with an
// add or compare stage behind it.
//
// Reset clears every valid bit and alpha. When the receiver stalls with a
// result waiting, every stage but the free-running alpha squarer holds in
// place and in_ready drops in the same cycle; nothing is dropped or repeated,
// and the pipe advances again as soon as the waiting result is taken.

module tetra_circumradius_alpha_test_unit #(
  parameter int COORD_BITS = tcat_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcat_pkg::ALPHA_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        v0_x,
  input  logic signed [COORD_BITS-1:0]        v0_y,
  input  logic signed [COORD_BITS-1:0]        v0_z,
  input  logic signed [COORD_BITS-1:0]        v1_x,
  input  logic signed [COORD_BITS-1:0]        v1_y,
  input  logic signed [COORD_BITS-1:0]        v1_z,
  input  logic signed [COORD_BITS-1:0]        v2_x,
  input  logic signed [COORD_BITS-1:0]        v2_y,
  input  logic signed [COORD_BITS-1:0]        v2_z,
  input  logic signed [COORD_BITS-1:0]        v3_x,
  input  logic signed [COORD_BITS-1:0]        v3_y,
  input  logic signed [COORD_BITS-1:0]        v3_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                keep,
  output logic                                degenerate
);

  import tcat_pkg::*;

  // Value widths, all exact for the coordinate range
  localparam int W_P   = COORD_BITS + 1;          // edge vector component
  localparam int W_PR  = 2 * W_P;                  // product of two components
  localparam int W_M   = 2 * COORD_BITS + 2;       // 2x2 minor
  localparam int W_S   = 2 * COORD_BITS + 3;       // squared edge length
  localparam int W_A   = 3 * COORD_BITS + 4;       // orientation determinant
  localparam int W_D   = 4 * COORD_BITS + 6;       // dx, dy, dz
  localparam int W_XM  = W_P + W_M;
  localparam int W_SM  = W_S + W_M;
  localparam int W_D2  = 2 * W_D;
  localparam int W_L   = W_D2 + 2;
  localparam int W_A2  = 2 * W_A;
  localparam int W_AL  = ALPHA_BITS + 1;
  localparam int W_AL2 = 2 * W_AL;
  localparam int W_AL4 = W_AL2 + 2;
  localparam int W_R   = W_A2 + W_AL4;
  localparam int W_CMP = (W_L > W_R) ? W_L : W_R;
  localparam int LAT   = 1 + 4 * (MUL_LAT + 1);

  logic                          en;
  logic [LAT-1:0]                vld;
  logic [ALPHA_BITS-1:0]         alpha;

  logic signed [COORD_BITS-1:0]  vin [4][3];
  logic signed [W_P-1:0]         p [3][3];
  logic signed [W_PR-1:0]        prm [3][3][2];
  logic signed [W_PR-1:0]        sqp [3][3];
  logic signed [W_M-1:0]         minor [3][3];
  logic signed [W_S-1:0]         sq [3];
  logic signed [W_P-1:0]         xd [3];
  logic signed [W_XM-1:0]        ta [3];
  logic signed [W_SM-1:0]        td [3][3];
  logic signed [W_A-1:0]         a_r;
  logic signed [W_D-1:0]         d_r [3];
  logic                          deg_r;
  logic signed [W_D2-1:0]        dsq [3];
  logic signed [W_A2-1:0]        asq;
  logic signed [W_AL2-1:0]       alpha_sq;
  logic signed [W_AL4-1:0]       alpha4;
  logic signed [W_L-1:0]         lhs_r;
  logic signed [W_A2-1:0]        a2_r;
  logic signed [W_R-1:0]         rhs;
  logic signed [W_L-1:0]         lhs_d;
  logic                          deg_d;

  // Hold the pipeline while a finished result waits for the receiver
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  assign vin[0] = '{v0_x, v0_y, v0_z};
  assign vin[1] = '{v1_x, v1_y, v1_z};
  assign vin[2] = '{v2_x, v2_y, v2_z};
  assign vin[3] = '{v3_x, v3_y, v3_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      alpha <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alpha <= cfg_data;
      end
      if (en) begin
        vld <= {vld[LAT-2:0], in_valid};
      end
    end
  end

  // Stage 1: move vertex 0 to the origin; c then vanishes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p[i][k] <= W_P'(vin[i+1][k]) - W_P'(vin[0][k]);
        end
      end
    end
  end

  // Round B: products of edge components, then 2x2 minors and squared lengths.
  // minor[i][g] drops row i; g picks the column pair yz, xz or xy.
  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam int J = (i == 0) ? 1 : 0;
    localparam int K = (i == 2) ? 1 : 2;
    for (genvar g = 0; g < 3; g++) begin : g_pair
      localparam int C0 = (g == 0) ? 1 : 0;
      localparam int C1 = (g == 2) ? 1 : 2;
      tcat_mul #(.WA(W_P), .WB(W_P), .WP(W_PR)) u_mul_m0 (
        .clk (clk), .en (en), .a (p[J][C0]), .b (p[K][C1]), .p (prm[i][g][0])
      );
      tcat_mul #(.WA(W_P), .WB(W_P), .WP(W_PR)) u_mul_m1 (
        .clk (clk), .en (en), .a (p[K][C0]), .b (p[J][C1]), .p (prm[i][g][1])
      );
      tcat_mul #(.WA(W_P), .WB(W_P), .WP(W_PR)) u_mul_sq (
        .clk (clk), .en (en), .a (p[i][g]), .b (p[i][g]), .p (sqp[i][g])
      );
    end
    // hold x beside the minors it meets in round C
    tcat_delay #(.WIDTH(W_P), .DEPTH(MUL_LAT + 1)) u_dly_x (
      .clk (clk), .en (en), .d (p[i][0]), .q (xd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int g = 0; g < 3; g++) begin
          minor[i][g] <= W_M'(prm[i][g][0]) - W_M'(prm[i][g][1]);
        end
        sq[i] <= W_S'(sqp[i][0]) + W_S'(sqp[i][1]) + W_S'(sqp[i][2]);
      end
    end
  end

  // Round C: expand a and dx, dy, dz along their first column
  for (genvar i = 0; i < 3; i++) begin : g_cof
    tcat_mul #(.WA(W_P), .WB(W_M), .WP(W_XM)) u_mul_a (
      .clk (clk), .en (en), .a (xd[i]), .b (minor[i][0]), .p (ta[i])
    );
    for (genvar g = 0; g < 3; g++) begin : g_d
      tcat_mul #(.WA(W_S), .WB(W_M), .WP(W_SM)) u_mul_d (
        .clk (clk), .en (en), .a (sq[i]), .b (minor[i][g]), .p (td[g][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= W_A'(ta[0]) - W_A'(ta[1]) + W_A'(ta[2]);
      deg_r <= (W_A'(ta[0]) - W_A'(ta[1]) + W_A'(ta[2])) == '0;
      for (int g = 0; g < 3; g++) begin
        d_r[g] <= W_D'(td[g][0]) - W_D'(td[g][1]) + W_D'(td[g][2]);
      end
    end
  end

  // Round D: squares. Alpha^2 runs free; user must write alpha only when idle
  for (genvar g = 0; g < 3; g++) begin : g_dsq
    tcat_mul #(.WA(W_D), .WB(W_D), .WP(W_D2)) u_mul_dsq (
      .clk (clk), .en (en), .a (d_r[g]), .b (d_r[g]), .p (dsq[g])
    );
  end

  tcat_mul #(.WA(W_A), .WB(W_A), .WP(W_A2)) u_mul_asq (
    .clk (clk), .en (en), .a (a_r), .b (a_r), .p (asq)
  );

  tcat_mul #(.WA(W_AL), .WB(W_AL), .WP(W_AL2)) u_mul_alpha (
    .clk (clk), .en (1'b1),
    .a   ({1'b0, alpha}), .b ({1'b0, alpha}), .p (alpha_sq)
  );

  assign alpha4 = {alpha_sq, 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r <= W_L'(dsq[0]) + W_L'(dsq[1]) + W_L'(dsq[2]);
      a2_r  <= asq;
    end
  end

  // Round E: right-hand side 4 * alpha^2 * a^2
  tcat_mul #(.WA(W_A2), .WB(W_AL4), .WP(W_R)) u_mul_rhs (
    .clk (clk), .en (en), .a (a2_r), .b (alpha4), .p (rhs)
  );

  tcat_delay #(.WIDTH(W_L), .DEPTH(MUL_LAT)) u_dly_lhs (
    .clk (clk), .en (en), .d (lhs_r), .q (lhs_d)
  );

  tcat_delay #(.WIDTH(1), .DEPTH(2 * MUL_LAT + 1)) u_dly_deg (
    .clk (clk), .en (en), .d (deg_r), .q (deg_d)
  );

  // Output register: a flat tetrahedron is never kept
  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= deg_d;
      keep       <= !deg_d && (W_CMP'(lhs_d) <= W_CMP'(rhs));
    end
  end

  a_keep_not_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(keep && degenerate))
    else $error("flat tetrahedron reported as kept");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted transfer not in first stage");

endmodule

FILE: test/tb_tetra_circumradius_alpha_test_unit.sv
`timescale 1ns / 1ps

module tb_tetra_circumradius_alpha_test_unit;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    logic keep;
    logic degenerate;
  } verdict_t;

  // Tracks the alpha register and predicts the keep / flat verdict of each
  // tetrahedron the block accepts, then matches them against its results
  // in order.
  class alpha_scoreboard;
    logic [tcat_pkg::ALPHA_BITS-1:0] alpha;
    verdict_t verdicts[$];
    int errors;
    int checked;
    int kept;
    int flat;

    function new();
      alpha = '0;
      errors = 0;
      checked = 0;
      kept = 0;
      flat = 0;
    endfunction

    // Cofactor expansion along the first row, kept exact at 256 bits.
    function wide_t det3(wide_t m[3][3]);
      wide_t acc;
      acc = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1]);
      acc = acc - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0]);
      acc = acc + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
      return acc;
    endfunction

    // Move vertex 0 to the origin; the test is translation invariant and the
    // constant determinant vanishes there.
    function void note_tetra(coord_t v[12]);
      wide_t p[3][3];
      wide_t sq[3];
      wide_t ma[3][3], mx[3][3], my[3][3], mz[3][3];
      wide_t a, dx, dy, dz, lhs, rhs, al;
      verdict_t vd;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p[i][k] = wide_t'(v[3 * (i + 1) + k]) - wide_t'(v[k]);
        end
        sq[i] = p[i][0] * p[i][0] + p[i][1] * p[i][1] + p[i][2] * p[i][2];
        ma[i][0] = p[i][0]; ma[i][1] = p[i][1]; ma[i][2] = p[i][2];
        mx[i][0] = sq[i];   mx[i][1] = p[i][1]; mx[i][2] = p[i][2];
        my[i][0] = sq[i];   my[i][1] = p[i][0]; my[i][2] = p[i][2];
        mz[i][0] = sq[i];   mz[i][1] = p[i][0]; mz[i][2] = p[i][1];
      end
      a = det3(ma);
      if (a == 0) begin
        vd.keep = 1'b0;
        vd.degenerate = 1'b1;
      end else begin
        dx = det3(mx);
        dy = det3(my);
        dz = det3(mz);
        lhs = dx * dx + dy * dy + dz * dz;
        al = wide_t'({232'd0, alpha});
        rhs = a * a * (al * al * 4);
        vd.keep = (lhs <= rhs);
        vd.degenerate = 1'b0;
      end
      verdicts.push_back(vd);
    endfunction

    function void check_result(logic keep, logic degenerate);
      verdict_t exp_v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result keep=%0b degenerate=%0b", $time, keep, degenerate);
        errors++;
        return;
      end
      exp_v = verdicts.pop_front();
      checked++;
      if (keep) kept++;
      if (degenerate) flat++;
      if (keep !== exp_v.keep) begin
        $display("%0t: keep mismatch: expected %0b, actual %0b", $time, exp_v.keep, keep);
        errors++;
      end
      if (degenerate !== exp_v.degenerate) begin
        $display("%0t: degenerate mismatch: expected %0b, actual %0b",
                 $time, exp_v.degenerate, degenerate);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [tcat_pkg::ALPHA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  coord_t crd[12];
  logic out_valid;
  logic out_ready;
  logic keep;
  logic degenerate;

  alpha_scoreboard sb;
  int sent;
  bit busy_mode;   // set: sender and receiver both run without idling

  tetra_circumradius_alpha_test_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .v0_x       (crd[0]),
    .v0_y       (crd[1]),
    .v0_z       (crd[2]),
    .v1_x       (crd[3]),
    .v1_y       (crd[4]),
    .v1_z       (crd[5]),
    .v2_x       (crd[6]),
    .v2_y       (crd[7]),
    .v2_z       (crd[8]),
    .v3_x       (crd[9]),
    .v3_y       (crd[10]),
    .v3_z       (crd[11]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .keep       (keep),
    .degenerate (degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one tetrahedron and hold it until the transfer happens.
  task automatic send_tetra(coord_t v[12]);
    @(negedge clk);
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) crd[i] <= v[i];
    do @(posedge clk); while (!in_ready);
    sb.note_tetra(v);
    sent++;
  endtask

  // Drop valid for the given gap after a transfer; zero keeps valid high.
  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Write alpha only once the pipe is drained, plus its full latency.
  task automatic write_alpha(logic [tcat_pkg::ALPHA_BITS-1:0] val);
    sender_gap(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.alpha = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_directed();
    coord_t v[12];
    coord_t lo, hi;
    lo = -16'sd32768;
    hi = 16'sd32767;
    // all vertices at the origin: flat
    foreach (v[i]) v[i] = '0;
    send_tetra(v);
    // unit corner tetrahedron
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_tetra(v);
    // same, shifted far off the origin
    v = '{30000, -30000, 30000, 30001, -30000, 30000,
          30000, -29999, 30000, 30000, -30000, 30001};
    send_tetra(v);
    // widest spread: opposite extremes on every axis
    v = '{lo, lo, lo, hi, lo, lo, lo, hi, lo, lo, lo, hi};
    send_tetra(v);
    v = '{hi, hi, hi, lo, hi, hi, hi, lo, hi, hi, hi, lo};
    send_tetra(v);
    v = '{lo, hi, lo, hi, lo, hi, hi, hi, lo, lo, lo, hi};
    send_tetra(v);
    // coplanar: all vertices on z = 7
    v = '{0, 0, 7, 100, 3, 7, -5, 40, 7, 900, -900, 7};
    send_tetra(v);
    // collinear and repeated vertices
    v = '{1, 1, 1, 2, 2, 2, 3, 3, 3, 9, 9, 9};
    send_tetra(v);
    v = '{hi, lo, hi, hi, lo, hi, 5, 6, 7, -1, 2, -3};
    send_tetra(v);
    // regular-ish tetrahedra of growing size, circumradius near small alphas
    v = '{1, 1, 1, 1, -1, -1, -1, 1, -1, -1, -1, 1};
    send_tetra(v);
    v = '{100, 100, 100, 100, -100, -100, -100, 100, -100, -100, -100, 100};
    send_tetra(v);
    v = '{hi, hi, hi, hi, lo, lo, lo, hi, lo, lo, lo, hi};
    send_tetra(v);
    // thin sliver: almost flat, huge circumradius
    v = '{0, 0, 0, 30000, 0, 0, 0, 30000, 0, 15000, 15000, 1};
    send_tetra(v);
    // all ones and alternating bit patterns
    v = '{-1, -1, -1, 16'sh5555, 16'shAAAA, 16'sh5555,
          16'shAAAA, 16'sh5555, 16'shAAAA, 0, 0, 1};
    send_tetra(v);
    sender_gap(1);
  endtask

  task automatic send_random(int count);
    coord_t v[12];
    int span, kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: span = 4;
        1: span = 64;
        2: span = 4096;
        default: span = 32767;
      endcase
      if (kind < 15) begin
        // full-range noise: every bit of every field toggles
        foreach (v[i]) v[i] = coord_t'($urandom());
      end else if (kind < 30) begin
        // coplanar by construction: v3 = v1 + v2 - v0
        if (span > 8000) span = 8000;
        for (int i = 0; i < 9; i++) v[i] = coord_t'($urandom_range(0, 2 * span) - span);
        for (int k = 0; k < 3; k++) v[9 + k] = v[3 + k] + v[6 + k] - v[k];
      end else if (kind < 35) begin
        // repeat one vertex
        foreach (v[i]) v[i] = coord_t'($urandom_range(0, 2 * span) - span);
        for (int k = 0; k < 3; k++) v[9 + k] = v[$urandom_range(0, 2) * 3 + k];
      end else begin
        // compact tetrahedron around a random centre
        for (int k = 0; k < 3; k++) begin
          int centre;
          centre = $urandom_range(0, 65535) - 32768;
          if (centre > 32767 - span) centre = 32767 - span;
          if (centre < -32768 + span) centre = -32768 + span;
          for (int j = 0; j < 4; j++)
            v[3 * j + k] = coord_t'(centre + $urandom_range(0, 2 * span) - span);
        end
      end
      send_tetra(v);
      sender_gap(idle_len());
    end
    sender_gap(1);
  endtask

  // Receiver: random back-pressure with runs of short and long stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (busy_mode) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
      end
      @(negedge clk);
    end
  end

  // Check each result transfer on the edge it happens.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(keep, degenerate);
    end
  end

  initial begin
    #2000000;
    $display("tetra_circumradius_alpha_test_unit test failed");
    $finish;
  end

  initial begin
    logic [tcat_pkg::ALPHA_BITS-1:0] settings[6];
    int drain;
    sb = new();
    sent = 0;
    busy_mode = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    foreach (crd[i]) crd[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // alpha left at its reset value first: nothing solid may be kept
    send_directed();
    send_random(300);

    settings = '{24'd1, 24'd3, 24'd100, 24'd5000, 24'hFFFFFF, 24'd0};
    settings[5] = tcat_pkg::ALPHA_BITS'($urandom_range(0, 24'hFFFFFF));
    foreach (settings[s]) begin
      write_alpha(settings[s]);
      busy_mode = (s == 2);
      if (s == 0 || s == 4) send_directed();
      send_random(260);
      busy_mode = 1'b0;
    end

    drain = 0;
    while (sb.pending() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d tetrahedra over 7 alpha settings; %0d results checked.",
             sent, sb.checked);
    $display("Results kept %0d, flat %0d; %0d mismatches.",
             sb.kept, sb.flat, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tetra_circumradius_alpha_test_unit test passed");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d results never arrived", $time, sb.pending());
      $display("tetra_circumradius_alpha_test_unit test failed");
    end
    $finish;
  end

endmodule
